// ===== src/alpha_weighted_pair_downscale_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the pair downscaler
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ALPHA_WEIGHTED_PAIR_DOWNSCALE_ASSERT_SVH
`define ALPHA_WEIGHTED_PAIR_DOWNSCALE_ASSERT_SVH

`ifndef SYNTHESIS

// Check that is switched off while reset is high
`define AWPD_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that also holds during reset
`define AWPD_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define AWPD_ASSERT(label, clk, rst, prop, msg)
`define AWPD_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

// ===== src/awpd_pkg.sv =====
// ----------------------------------------------------------------------------
// awpd_pkg
// Shared widths, constants and pipeline types of the pair downscaler.
// ----------------------------------------------------------------------------
package awpd_pkg;

  localparam int ChanWidth = 8;
  // two 8x8 products summed
  localparam int SumWidth  = 2 * ChanWidth + 1;
  // divisor is twice the half alpha
  localparam int DivWidth  = ChanWidth + 1;
  // one quotient bit per divider stage
  localparam int DivSteps  = ChanWidth;
  localparam int NumColors = 3;
  // product stage, sum stage, divider stages, output register
  localparam int Latency   = 2 + DivSteps + 1;

  localparam logic [ChanWidth-1:0] ChanMax = '1;

  // Color index within a lane array
  localparam int ColorRed   = 0;
  localparam int ColorGreen = 1;
  localparam int ColorBlue  = 2;

  // One color on its way through the divider
  typedef struct packed {
    logic [DivWidth-1:0]  rem;   // partial remainder, below divisor unless sat
    logic [ChanWidth-1:0] low;   // dividend bits not yet brought down
    logic [ChanWidth-1:0] quo;   // quotient bits so far
    logic                 sat;   // quotient would exceed ChanMax
  } awpd_lane_t;

  // Payload carried by every divider stage
  typedef struct packed {
    awpd_lane_t [NumColors-1:0] lane;
    logic [DivWidth-1:0]        divisor;
    logic                       zero;   // half alpha is zero
    logic [ChanWidth-1:0]       alpha;
  } awpd_stage_t;

endpackage

// ===== src/awpd_weight.sv =====
// ----------------------------------------------------------------------------
// awpd_weight
// Alpha weighting front end: products, sums, divisor and saturation flag.
// ----------------------------------------------------------------------------
module awpd_weight (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          valid_in,
  input  logic [awpd_pkg::ChanWidth-1:0] first_red,
  input  logic [awpd_pkg::ChanWidth-1:0] first_green,
  input  logic [awpd_pkg::ChanWidth-1:0] first_blue,
  input  logic [awpd_pkg::ChanWidth-1:0] first_alpha,
  input  logic [awpd_pkg::ChanWidth-1:0] second_red,
  input  logic [awpd_pkg::ChanWidth-1:0] second_green,
  input  logic [awpd_pkg::ChanWidth-1:0] second_blue,
  input  logic [awpd_pkg::ChanWidth-1:0] second_alpha,
  output logic                          valid_out,
  output awpd_pkg::awpd_stage_t         stage_out
);

  localparam int CW = awpd_pkg::ChanWidth;
  localparam int NC = awpd_pkg::NumColors;
  localparam int PW = 2 * CW;

  logic [CW-1:0] first_color  [NC];
  logic [CW-1:0] second_color [NC];

  // stage 1 registers
  logic          prod_valid;
  logic [PW-1:0] first_prod  [NC];
  logic [PW-1:0] second_prod [NC];
  logic [CW:0]   alpha_sum;

  // stage 2 combinational
  logic [CW-1:0]                   half_alpha;
  logic [awpd_pkg::DivWidth-1:0]   divisor;
  logic [awpd_pkg::SumWidth-1:0]   weighted [NC];
  awpd_pkg::awpd_stage_t           stage_next;

  assign first_color[awpd_pkg::ColorRed]    = first_red;
  assign first_color[awpd_pkg::ColorGreen]  = first_green;
  assign first_color[awpd_pkg::ColorBlue]   = first_blue;
  assign second_color[awpd_pkg::ColorRed]   = second_red;
  assign second_color[awpd_pkg::ColorGreen] = second_green;
  assign second_color[awpd_pkg::ColorBlue]  = second_blue;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      valid_out  <= 1'b0;
    end else begin
      prod_valid <= valid_in;
      valid_out  <= prod_valid;
    end
  end

  // stage 1: color times alpha
  always_ff @(posedge clk) begin
    for (int c = 0; c < NC; c++) begin
      first_prod[c]  <= first_color[c] * first_alpha;
      second_prod[c] <= second_color[c] * second_alpha;
    end
    alpha_sum <= {1'b0, first_alpha} + {1'b0, second_alpha};
  end

  // stage 2: sums, divisor = 2 * half alpha, overflow test
  assign half_alpha = alpha_sum[CW:1];
  assign divisor    = {half_alpha, 1'b0};

  always_comb begin
    stage_next = '0;
    for (int c = 0; c < NC; c++) begin
      weighted[c] = {1'b0, first_prod[c]} + {1'b0, second_prod[c]};
      stage_next.lane[c].rem = weighted[c][awpd_pkg::SumWidth-1:CW];
      stage_next.lane[c].low = weighted[c][CW-1:0];
      stage_next.lane[c].quo = '0;
      // quotient reaches 256 or more exactly when the top bits reach the divisor
      stage_next.lane[c].sat = (weighted[c][awpd_pkg::SumWidth-1:CW] >= divisor);
    end
    stage_next.divisor = divisor;
    stage_next.zero    = (half_alpha == '0);
    stage_next.alpha   = half_alpha;
  end

  always_ff @(posedge clk) begin
    stage_out <= stage_next;
  end

endmodule

// ===== src/awpd_div_step.sv =====
// ----------------------------------------------------------------------------
// awpd_div_step
// One restoring division step for all three colors: one quotient bit each.
// ----------------------------------------------------------------------------
module awpd_div_step (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  valid_in,
  input  awpd_pkg::awpd_stage_t stage_in,
  output logic                  valid_out,
  output awpd_pkg::awpd_stage_t stage_out
);

  localparam int DW = awpd_pkg::DivWidth;
  localparam int CW = awpd_pkg::ChanWidth;

  logic [DW:0]           shifted [awpd_pkg::NumColors];
  logic [DW:0]           diff    [awpd_pkg::NumColors];
  logic                  fits    [awpd_pkg::NumColors];
  awpd_pkg::awpd_stage_t stage_next;

  // bring down next dividend bit, subtract when it fits
  always_comb begin
    stage_next = stage_in;
    for (int c = 0; c < awpd_pkg::NumColors; c++) begin
      shifted[c] = {stage_in.lane[c].rem, stage_in.lane[c].low[CW-1]};
      diff[c]    = shifted[c] - {1'b0, stage_in.divisor};
      fits[c]    = (shifted[c] >= {1'b0, stage_in.divisor});
      stage_next.lane[c].rem = fits[c] ? diff[c][DW-1:0] : shifted[c][DW-1:0];
      stage_next.lane[c].low = {stage_in.lane[c].low[CW-2:0], 1'b0};
      stage_next.lane[c].quo = {stage_in.lane[c].quo[CW-2:0], fits[c]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    stage_out <= stage_next;
  end

endmodule

// ===== src/alpha_weighted_pair_downscale.sv =====
// ----------------------------------------------------------------------------
// alpha_weighted_pair_downscale
// Merges two adjacent RGBA pixels into one, colors weighted by alpha.
// ----------------------------------------------------------------------------
//
//   channel   signals                               handshake
//   -------   -----------------------------------   -------------------------
//   input     first_*, second_* (red/green/blue/     start high, busy low
//             alpha)
//   result    out_red, out_green, out_blue,          done, one cycle, no hold
//             out_alpha
//
// One transaction per clock. A result passes through one product stage,
// one sum stage, eight restoring division stages (one quotient bit each)
// and the output register. busy stays low; the pipeline never stalls.
// Synchronous reset clears the valid bits of every stage, so transactions
// in flight are dropped.
// ----------------------------------------------------------------------------
`include "alpha_weighted_pair_downscale_assert.svh"

module alpha_weighted_pair_downscale (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [7:0] first_red,
  input  logic [7:0] first_green,
  input  logic [7:0] first_blue,
  input  logic [7:0] first_alpha,
  input  logic [7:0] second_red,
  input  logic [7:0] second_green,
  input  logic [7:0] second_blue,
  input  logic [7:0] second_alpha,
  output logic       done,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue,
  output logic [7:0] out_alpha
);

  localparam int Steps = awpd_pkg::DivSteps;

  logic                  accept;
  logic                  stage_valid [Steps+1];
  awpd_pkg::awpd_stage_t stage       [Steps+1];
  logic [7:0]            color_next  [awpd_pkg::NumColors];

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // weighting front end
  awpd_weight u_weight (
    .clk          (clk),
    .rst          (rst),
    .valid_in     (accept),
    .first_red    (first_red),
    .first_green  (first_green),
    .first_blue   (first_blue),
    .first_alpha  (first_alpha),
    .second_red   (second_red),
    .second_green (second_green),
    .second_blue  (second_blue),
    .second_alpha (second_alpha),
    .valid_out    (stage_valid[0]),
    .stage_out    (stage[0])
  );

  // divider chain
  for (genvar s = 0; s < Steps; s++) begin : g_div
    awpd_div_step u_step (
      .clk       (clk),
      .rst       (rst),
      .valid_in  (stage_valid[s]),
      .stage_in  (stage[s]),
      .valid_out (stage_valid[s+1]),
      .stage_out (stage[s+1])
    );
  end

  // zero alpha, saturation, quotient
  always_comb begin
    for (int c = 0; c < awpd_pkg::NumColors; c++) begin
      if (stage[Steps].zero) begin
        color_next[c] = '0;
      end else if (stage[Steps].lane[c].sat) begin
        color_next[c] = awpd_pkg::ChanMax;
      end else begin
        color_next[c] = stage[Steps].lane[c].quo;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= stage_valid[Steps];
    end
  end

  always_ff @(posedge clk) begin
    out_red   <= color_next[awpd_pkg::ColorRed];
    out_green <= color_next[awpd_pkg::ColorGreen];
    out_blue  <= color_next[awpd_pkg::ColorBlue];
    out_alpha <= stage[Steps].alpha;
  end

  // checks
  `AWPD_ASSERT(a_start_gives_done, clk, rst, accept |-> ##11 done, "start without result")
  `AWPD_ASSERT(a_done_has_start, clk, rst, done |-> $past(accept, 11), "result without start")
  `AWPD_ASSERT(a_alpha_tracks, clk, rst, done |-> (out_alpha == $past((({1'b0, first_alpha} + {1'b0, second_alpha}) >> 1), 11)), "alpha mismatch")
  `AWPD_ASSERT(a_zero_alpha_black, clk, rst, (done && out_alpha == '0) |-> (out_red == '0 && out_green == '0 && out_blue == '0), "color on zero alpha")
  `AWPD_ASSERT_ALWAYS(a_reset_clears, clk, rst |=> !done, "result right after reset")

endmodule
